>>> design/i128a_pkg.sv
// shared types, operation codes and constants of the 128-bit alu
package i128a_pkg;

  localparam int WORD_BITS = 128;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int LIMB_BITS = 32;
  localparam int SHAMT_BITS = 7;
  localparam int CMD_BITS = 4;
  localparam int IN_BITS = 272;
  localparam int OUT_BITS = 128;
  // main stage at whose input the product joins the item
  localparam int MUL_JOIN = 3;
  localparam int LAST_STAGE = WORD_BITS + 1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_AND = 4'd4,
    CMD_OR  = 4'd5,
    CMD_XOR = 4'd6,
    CMD_NOT = 4'd7,
    CMD_SHL = 4'd8,
    CMD_SAR = 4'd9,
    CMD_ROL = 4'd10,
    CMD_ROR = 4'd11
  } cmd_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]    cmd;
    logic                   neg;
    logic                   dz;
    logic [WORD_BITS-1:0]   res;
    logic [2*WORD_BITS-1:0] rq;
    logic [WORD_BITS-1:0]   den;
  } item_t;

endpackage

>>> design/i128a_prep.sv
// first stage: simple operations and divide operand magnitudes
module i128a_prep (
  input  logic                            clk,
  input  logic                            en,
  input  logic [i128a_pkg::CMD_BITS-1:0]  cmd,
  input  logic [i128a_pkg::WORD_BITS-1:0] a,
  input  logic [i128a_pkg::WORD_BITS-1:0] b,
  input  logic [i128a_pkg::SHAMT_BITS-1:0] shamt,
  output i128a_pkg::item_t                item
);
  import i128a_pkg::*;

  item_t nxt;
  logic sa, sb;

  always_comb begin
    sa = a[WORD_BITS-1];
    sb = b[WORD_BITS-1];
    nxt.cmd = cmd;
    nxt.neg = sa ^ sb;
    nxt.dz = (cmd == CMD_DIV) && (b == '0);
    nxt.rq = {{WORD_BITS{1'b0}}, (sa ? (~a + 1'b1) : a)};
    nxt.den = sb ? (~b + 1'b1) : b;
    case (cmd)
      CMD_ADD: nxt.res = a + b;
      CMD_SUB: nxt.res = a - b;
      CMD_AND: nxt.res = a & b;
      CMD_OR:  nxt.res = a | b;
      CMD_XOR: nxt.res = a ^ b;
      CMD_NOT: nxt.res = ~a;
      CMD_SHL: nxt.res = a << shamt;
      CMD_SAR: nxt.res = WORD_BITS'($signed(a) >>> shamt);
      CMD_ROL: nxt.res = {a[WORD_BITS-2:0], a[WORD_BITS-1]};
      CMD_ROR: nxt.res = {a[0], a[WORD_BITS-1:1]};
      default: nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= nxt;
    end
  end

endmodule

>>> design/i128a_mul.sv
// three-stage low-half multiplier built from 32x32 limb products
module i128a_mul (
  input  logic                            clk,
  input  logic [2:0]                      en,
  input  logic [i128a_pkg::WORD_BITS-1:0] a,
  input  logic [i128a_pkg::WORD_BITS-1:0] b,
  output logic [i128a_pkg::WORD_BITS-1:0] prod
);
  import i128a_pkg::*;

  localparam int L = LIMB_BITS;

  // limb products a[i]*b[j] with i+j below four
  logic [2*L-1:0] p00, p01, p10, p02, p11, p20, p03, p12, p21, p30;
  logic [2*L:0]   c1;
  logic [2*L+1:0] c2;
  logic [L-1:0]   c3;
  logic [L-1:0]   c0h;
  logic [L-1:0]   c0l;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p00 <= a[L-1:0] * b[L-1:0];
      p01 <= a[L-1:0] * b[2*L-1:L];
      p10 <= a[2*L-1:L] * b[L-1:0];
      p02 <= a[L-1:0] * b[3*L-1:2*L];
      p11 <= a[2*L-1:L] * b[2*L-1:L];
      p20 <= a[3*L-1:2*L] * b[L-1:0];
      p03 <= a[L-1:0] * b[4*L-1:3*L];
      p12 <= a[2*L-1:L] * b[3*L-1:2*L];
      p21 <= a[3*L-1:2*L] * b[2*L-1:L];
      p30 <= a[4*L-1:3*L] * b[L-1:0];
    end
    if (en[1]) begin
      c0l <= p00[L-1:0];
      c0h <= p00[2*L-1:L];
      c1  <= {1'b0, p01} + {1'b0, p10};
      c2  <= {2'b0, p02} + {2'b0, p11} + {2'b0, p20};
      c3  <= p03[L-1:0] + p12[L-1:0] + p21[L-1:0] + p30[L-1:0];
    end
    if (en[2]) begin
      // top limb sum sits at bit 96, the low product fills bits 63..0
      prod <= {c3, {L{1'b0}}, c0h, c0l}
            + {{(WORD_BITS-3*L-1){1'b0}}, c1, {L{1'b0}}}
            + {c2[2*L-1:0], {(2*L){1'b0}}};
    end
  end

endmodule

>>> design/i128a_div_step.sv
// one registered step of the restoring divider
module i128a_div_step (
  input  logic             clk,
  input  logic             en,
  input  i128a_pkg::item_t din,
  output i128a_pkg::item_t dout
);
  import i128a_pkg::*;

  item_t nxt;
  logic [WORD_BITS:0] trial;
  logic [WORD_BITS:0] diff;

  always_comb begin
    nxt = din;
    trial = din.rq[2*WORD_BITS-1:WORD_BITS-1];
    diff = trial - {1'b0, din.den};
    nxt.rq = {din.rq[2*WORD_BITS-2:0], 1'b0};
    if (!diff[WORD_BITS]) begin
      nxt.rq[2*WORD_BITS-1:WORD_BITS] = diff[WORD_BITS-1:0];
      nxt.rq[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

>>> design/int128_alu_core.sv
// top level of the pipelined 128-bit alu
// throughput: one transaction per cycle while the output is not stalled;
// the 128-step restoring divider sets the depth
// multiply runs in a three-stage limb multiplier beside the divider pipeline
// the first stage refills while the output is stalled if it is empty
// rst is synchronous and clears only the stage valid bits
module int128_alu_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd[3:0], operand_a_high[67:4], operand_a_low[131:68],
  // operand_b_high[195:132], operand_b_low[259:196], shift_amount[266:260], zero fill
  input  logic [i128a_pkg::IN_BITS-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result_high[63:0], result_low[127:64]
  output logic [i128a_pkg::OUT_BITS-1:0]  m_tdata,
  // divide_by_zero[0]
  output logic                            m_tuser
);
  import i128a_pkg::*;

  logic [CMD_BITS-1:0]   in_cmd;
  logic [WORD_BITS-1:0]  in_a;
  logic [WORD_BITS-1:0]  in_b;
  logic [SHAMT_BITS-1:0] in_shamt;

  // unpack the input transaction
  assign in_cmd   = s_tdata[3:0];
  assign in_a     = {s_tdata[67:4], s_tdata[131:68]};
  assign in_b     = {s_tdata[195:132], s_tdata[259:196]};
  assign in_shamt = s_tdata[266:260];

  logic [LAST_STAGE:0] vld;
  logic [LAST_STAGE:0] en;
  logic                adv;

  // whole pipeline moves when the output register is free or drained
  assign adv = !vld[LAST_STAGE] || m_tready;

  always_comb begin
    en = {(LAST_STAGE+1){adv}};
    en[0] = adv || !vld[0];
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k <= LAST_STAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage items: index 0 is prep, 1..WORD_BITS are divider steps
  item_t st [WORD_BITS+1];
  logic [WORD_BITS-1:0] prod;

  i128a_prep u_prep (
    .clk   (clk),
    .en    (en[0]),
    .cmd   (in_cmd),
    .a     (in_a),
    .b     (in_b),
    .shamt (in_shamt),
    .item  (st[0])
  );

  // product register lines up with main stage MUL_JOIN-1
  i128a_mul u_mul (
    .clk  (clk),
    .en   (en[2:0]),
    .a    (in_a),
    .b    (in_b),
    .prod (prod)
  );

  genvar g;
  generate
    for (g = 1; g <= WORD_BITS; g++) begin : g_div
      item_t din;
      always_comb begin
        din = st[g-1];
        if (g == MUL_JOIN && st[g-1].cmd == CMD_MUL) begin
          din.res = prod;
        end
      end
      i128a_div_step u_step (
        .clk  (clk),
        .en   (en[g]),
        .din  (din),
        .dout (st[g])
      );
    end
  endgenerate

  // output register: pick the quotient with its sign (zero on divide by zero), or the carried result
  item_t               fin;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] out_res;
  logic                 out_dz;

  assign fin = st[WORD_BITS];
  assign quo = fin.rq[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en[LAST_STAGE]) begin
      if (fin.cmd == CMD_DIV) begin
        out_dz <= fin.dz;
        if (fin.dz) begin
          out_res <= '0;
        end else begin
          out_res <= fin.neg ? (~quo + 1'b1) : quo;
        end
      end else begin
        out_dz  <= 1'b0;
        out_res <= fin.res;
      end
    end
  end

  assign m_tvalid = vld[LAST_STAGE];
  assign m_tdata  = {out_res[HALF_BITS-1:0], out_res[WORD_BITS-1:HALF_BITS]};
  assign m_tuser  = out_dz;

endmodule

>>> design/i128a_checker.sv
// port-level checks for the 128-bit alu, bound to the top level
module i128a_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         m_tuser
);

  // a divide by zero always comes with a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("divide by zero with nonzero result");

  // a stalled output transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output register never holds back input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with free output");

endmodule

bind int128_alu_core i128a_checker u_i128a_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/int128_alu_checker.sv
// checker for the 128-bit alu: predicts each result and compares it with the output stream
module int128_alu_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [i128a_pkg::IN_BITS-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [i128a_pkg::OUT_BITS-1:0] m_tdata,
  input  logic                           m_tuser,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count
);
  import i128a_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        dz;
  } alu_result_t;

  alu_result_t result_fifo[$];

  function automatic alu_result_t alu_compute(logic [IN_BITS-1:0] d);
    logic [3:0]   op;
    logic [127:0] a, b, r, ma, mb, q;
    logic [6:0]   amt;
    alu_result_t  o;
    op  = d[3:0];
    a   = {d[67:4], d[131:68]};
    b   = {d[195:132], d[259:196]};
    amt = d[266:260];
    r   = '0;
    o.dz = 1'b0;
    case (op)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = a * b;
      CMD_DIV: begin
        if (b == '0) begin
          o.dz = 1'b1;
        end else begin
          ma = a[127] ? -a : a;
          mb = b[127] ? -b : b;
          q  = ma / mb;
          r  = (a[127] != b[127]) ? -q : q;
        end
      end
      CMD_AND: r = a & b;
      CMD_OR:  r = a | b;
      CMD_XOR: r = a ^ b;
      CMD_NOT: r = ~a;
      CMD_SHL: r = a << amt;
      CMD_SAR: r = $signed(a) >>> amt;
      CMD_ROL: r = {a[126:0], a[127]};
      CMD_ROR: r = {a[0], a[127:1]};
      default: r = '0;
    endcase
    o.hi = r[127:64];
    o.lo = r[63:0];
    return o;
  endfunction

  assign pending = result_fifo.size();

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result hi=%h lo=%h dz=%b", $time,
                   m_tdata[63:0], m_tdata[127:64], m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want.hi !== m_tdata[63:0] || want.lo !== m_tdata[127:64] ||
              want.dz !== m_tuser) begin
            $display("%0t: mismatch expected hi=%h lo=%h dz=%b actual hi=%h lo=%h dz=%b",
                     $time, want.hi, want.lo, want.dz, m_tdata[63:0], m_tdata[127:64],
                     m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) result_fifo.push_back(alu_compute(s_tdata));
    end
  end
endmodule

>>> verif/testbench.sv
// stimulus and verdict for the 128-bit alu core
module testbench;
  import i128a_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_BITS-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_tdata;
  logic                 m_tuser;
  int                   fail_count, pending, result_count;
  int                   sent = 0;
  bit                   hold_off = 1'b0;

  localparam logic [127:0] MOST_NEG = {1'b1, 127'b0};
  localparam logic [127:0] ALL_ONES = '1;

  always #5 clk = ~clk;

  int128_alu_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  int128_alu_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  function automatic logic [127:0] rand_word();
    logic [127:0] w;
    w = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = ALL_ONES;
      2: w = MOST_NEG;
      3: w = ~MOST_NEG;
      4: w = 128'(signed'($urandom_range(0, 40)) - 20);
      5: w = w >> $urandom_range(0, 127);
      6: w = 128'($signed(w) >>> $urandom_range(0, 127));
      default: ;
    endcase
    return w;
  endfunction

  // hand one input transaction to the block; valid stays up across back-to-back items
  task automatic send_op(logic [3:0] op, logic [127:0] a, logic [127:0] b, logic [6:0] amt);
    s_tdata  <= {5'b0, amt, b[63:0], b[127:64], a[63:0], a[127:64], op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver: random stall pattern, with one long hold-off on request
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = $urandom_range(0, 3);
      m_tready <= (stall != 0) || (result_count < 300);
      @(negedge clk);
    end
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [3:0] op;
    int burst;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every code, extreme operands, special cases
    for (int c = 0; c < 16; c++) send_op(4'(c), ALL_ONES, MOST_NEG, 7'd127);
    send_op(CMD_DIV, MOST_NEG, ALL_ONES, 7'd0);
    send_op(CMD_DIV, 128'd7, '0, 7'd0);
    send_op(CMD_DIV, -128'sd7, 128'd2, 7'd0);
    send_op(CMD_DIV, 128'd7, -128'sd2, 7'd0);
    send_op(CMD_SHL, MOST_NEG | 128'd1, '0, 7'd0);
    send_op(CMD_SAR, MOST_NEG, '0, 7'd64);
    send_op(CMD_SAR, MOST_NEG, '0, 7'd1);
    send_op(CMD_MUL, MOST_NEG, ALL_ONES, 7'd0);
    send_op(CMD_ROR, 128'd1, '0, 7'd0);

    // sender pauses until every result is back
    idle_gap(1);
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 1650; i++) begin
      if (i == 200) hold_off = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      send_op(op, rand_word(), rand_word(), 7'($urandom));
      burst = $urandom_range(0, 7);
      if (burst == 0 && i > 400) idle_gap($urandom_range(1, 6));
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    $display("covered %0d input transactions over all operation codes, with stalls and drains",
             sent);
    $display("received %0d results", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
